@@ sv/light_start_detector_defines.svh @@
// Assertion macros for the light start detector checker.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef LIGHT_START_DETECTOR_DEFINES_SVH
`define LIGHT_START_DETECTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define LSD_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LSD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/lsd_pkg.sv @@
// Shared constants and status codes for the light start detector.
// Used by the top level and by its port checker; depends on nothing.
package lsd_pkg;

  localparam int SAMPLE_BITS   = 12;
  localparam int FRACTION_BITS = 8;
  localparam int FILTER_W      = SAMPLE_BITS + FRACTION_BITS;

  localparam int LEVEL_W    = 12;
  localparam int ELAPSED_W  = 10;
  localparam int WINDOW_W   = 16;
  localparam int BAND_W     = 8;
  localparam int THRESH_W   = 13;
  localparam int STATUS_W   = 3;
  localparam int FILTOUT_W  = 12;
  localparam int TIMER_W    = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 48;

  localparam logic [LEVEL_W-1:0] MIN_GAP      = LEVEL_W'(100);
  localparam logic [LEVEL_W-1:0] SHIELD_LIMIT = LEVEL_W'(1000);

  localparam int WEIGHT_NEW   = 77;
  localparam int WEIGHT_OLD   = 179;
  localparam int WEIGHT_SHIFT = 8;

  // Division by ten as a multiply by 6554 / 2^16; exact for 12-bit values.
  localparam int DIV10_MUL   = 6554;
  localparam int DIV10_SHIFT = 16;

  localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

  localparam logic [1:0] MODE_WATCH   = 2'd0;
  localparam logic [1:0] MODE_CONFIRM = 2'd1;
  localparam logic [1:0] MODE_DETECT  = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_WATCH   = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_CONFIRM = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_DETECT  = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_SHIELD  = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_CLOSE   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_ON_LEVEL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_LEVEL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BAND      = 2'd3;

endpackage

@@ sv/light_start_detector.sv @@
// Light start detector: filtered light level with hysteresis thresholds
// and a confirmation window. Depends on lsd_pkg.
//
// An accepted item goes into the input register, then the result register.
// Throughput: one item per cycle while the output is not stalled; the filter
// update and mode step for an item are one pass of logic between the two registers.
// Reset: rst (synchronous) restores the calibration registers, clears the
// filter and timer, returns the mode to watching and empties both stages.
module light_start_detector (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [11:0] light_sample, [21:12] elapsed_ms, [23:22] zero
  input  logic [lsd_pkg::IN_DATA_W-1:0]    s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [2:0] detect_status, [14:3] filtered_level, [27:15] low_level,
  // [40:28] high_level, [47:41] zero
  output logic [lsd_pkg::OUT_DATA_W-1:0]   m_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [lsd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lsd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import lsd_pkg::*;

  localparam int MUL_W = FILTER_W + 9;
  localparam int DIV_W = LEVEL_W + 13;
  localparam int QUO_W = THRESH_W - 1;

  // Calibration registers.
  logic [LEVEL_W-1:0]  on_level;
  logic [LEVEL_W-1:0]  off_level;
  logic [WINDOW_W-1:0] window_ms;
  logic [BAND_W-1:0]   band;

  // Item state.
  logic [FILTER_W-1:0] filter_value, filter_next;
  logic [1:0]          detect_mode, detect_mode_next;
  logic [TIMER_W-1:0]  window_timer, window_timer_next;

  // Input register.
  logic                 in_valid;
  logic [LEVEL_W-1:0]   in_sample;
  logic [ELAPSED_W-1:0] in_elapsed;

  // Result register.
  logic                 out_valid;
  logic [STATUS_W-1:0]  out_status, out_status_next;
  logic [FILTOUT_W-1:0] out_filtered, out_filtered_next;
  logic [THRESH_W-1:0]  out_low, out_low_next;
  logic [THRESH_W-1:0]  out_high, out_high_next;

  logic advance;

  // Thresholds and calibration check.
  logic [THRESH_W-1:0] gap;
  logic                bad_cal;
  logic [DIV_W-1:0]    gap_prod;
  logic [QUO_W-1:0]    gap_tenth;
  logic [THRESH_W-1:0] low_level, high_level;
  logic [THRESH_W+FRACTION_BITS-1:0] low_fx, high_fx;

  // Filter and timer.
  logic [SAMPLE_BITS-1:0] sample;
  logic [FILTER_W-1:0]    sample_fx;
  logic [MUL_W-1:0]       filter_sum;
  logic [FILTER_W-1:0]    filter_upd;
  logic [TIMER_W:0]       timer_sum;
  logic [TIMER_W-1:0]     timer_sat;
  logic [THRESH_W+FRACTION_BITS-1:0] filter_ext;

  assign cfg_ready = 1'b1;
  assign advance   = in_valid && (!out_valid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign m_tvalid  = out_valid;
  assign m_tdata   = {7'd0, out_high, out_low, out_filtered, out_status};

  assign gap       = {1'b0, off_level} - {1'b0, on_level};
  assign bad_cal   = gap[THRESH_W-1] || (gap[LEVEL_W-1:0] <= MIN_GAP);
  assign gap_prod  = DIV_W'(gap[LEVEL_W-1:0]) * DIV_W'(DIV10_MUL);
  assign gap_tenth = QUO_W'(gap_prod >> DIV10_SHIFT);
  assign low_level  = THRESH_W'(on_level) + THRESH_W'(gap_tenth);
  assign high_level = low_level + THRESH_W'(band);
  assign low_fx     = {low_level, {FRACTION_BITS{1'b0}}};
  assign high_fx    = {high_level, {FRACTION_BITS{1'b0}}};

  assign sample     = SAMPLE_BITS'(in_sample);
  assign sample_fx  = {sample, {FRACTION_BITS{1'b0}}};
  assign filter_sum = MUL_W'(sample_fx) * MUL_W'(WEIGHT_NEW)
                    + MUL_W'(filter_value) * MUL_W'(WEIGHT_OLD);
  assign filter_upd = FILTER_W'(filter_sum >> WEIGHT_SHIFT);
  assign filter_ext = (THRESH_W + FRACTION_BITS)'(filter_upd);

  assign timer_sum = {1'b0, window_timer} + (TIMER_W + 1)'(in_elapsed);
  assign timer_sat = timer_sum[TIMER_W] ? TIMER_MAX : timer_sum[TIMER_W-1:0];

  always_comb begin
    filter_next       = filter_value;
    detect_mode_next  = detect_mode;
    window_timer_next = window_timer;
    out_status_next   = STAT_WATCH;
    out_low_next      = '0;
    out_high_next     = '0;
    if (bad_cal) begin
      // State is held; only the status and the held filter are reported.
      out_status_next = (off_level < SHIELD_LIMIT) ? STAT_SHIELD : STAT_CLOSE;
    end else begin
      filter_next   = filter_upd;
      out_low_next  = low_level;
      out_high_next = high_level;
      case (detect_mode)
        MODE_CONFIRM: begin
          window_timer_next = timer_sat;
          if (filter_ext > high_fx) begin
            detect_mode_next = MODE_WATCH;
          end else if (timer_sat >= TIMER_W'(window_ms)) begin
            detect_mode_next = (filter_ext < low_fx) ? MODE_DETECT : MODE_WATCH;
          end
        end
        MODE_DETECT: begin
          detect_mode_next = MODE_DETECT;
        end
        default: begin
          detect_mode_next = MODE_WATCH;
          if (filter_ext < low_fx) begin
            detect_mode_next  = MODE_CONFIRM;
            window_timer_next = '0;
          end
        end
      endcase
      out_status_next = STATUS_W'(detect_mode_next);
    end
    out_filtered_next = FILTOUT_W'(filter_next >> FRACTION_BITS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      on_level  <= '0;
      off_level <= '1;
      window_ms <= WINDOW_W'(1000);
      band      <= BAND_W'(5);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ON_LEVEL:  on_level  <= cfg_data[LEVEL_W-1:0];
        REG_OFF_LEVEL: off_level <= cfg_data[LEVEL_W-1:0];
        REG_WINDOW:    window_ms <= cfg_data[WINDOW_W-1:0];
        REG_BAND:      band      <= cfg_data[BAND_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid     <= 1'b0;
      out_valid    <= 1'b0;
      filter_value <= '0;
      detect_mode  <= MODE_WATCH;
      window_timer <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        out_valid    <= 1'b1;
        filter_value <= filter_next;
        detect_mode  <= detect_mode_next;
        window_timer <= window_timer_next;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_sample  <= s_tdata[LEVEL_W-1:0];
      in_elapsed <= s_tdata[LEVEL_W +: ELAPSED_W];
    end
    if (advance) begin
      out_status   <= out_status_next;
      out_filtered <= out_filtered_next;
      out_low      <= out_low_next;
      out_high     <= out_high_next;
    end
  end

endmodule

@@ sv/lsd_checker.sv @@
// Port-level checker for the light start detector, bound to the top level.
// Depends on lsd_pkg and light_start_detector_defines.svh.
`include "light_start_detector_defines.svh"

module lsd_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [lsd_pkg::OUT_DATA_W-1:0] m_tdata
);
  import lsd_pkg::*;

  logic [STATUS_W-1:0] status;
  logic [THRESH_W-1:0] low_lvl;
  logic [THRESH_W-1:0] high_lvl;
  logic                cal_bad;

  assign status   = m_tdata[STATUS_W-1:0];
  assign low_lvl  = m_tdata[STATUS_W+FILTOUT_W +: THRESH_W];
  assign high_lvl = m_tdata[STATUS_W+FILTOUT_W+THRESH_W +: THRESH_W];
  assign cal_bad  = (status == STAT_SHIELD) || (status == STAT_CLOSE);

  // A stalled result is held.
  `LSD_ASSERT_NEXT(a_stall_hold, clk, rst, m_tvalid && !m_tready,
    m_tvalid && $stable(m_tdata), "result changed while stalled")

  `LSD_ASSERT_NOW(a_status_code, clk, rst, m_tvalid,
    status == STAT_WATCH || status == STAT_CONFIRM || status == STAT_DETECT || cal_bad,
    "undefined status code")

  `LSD_ASSERT_NOW(a_bad_cal_zero, clk, rst, m_tvalid && cal_bad,
    low_lvl == '0 && high_lvl == '0, "thresholds reported on bad calibration")

  `LSD_ASSERT_NOW(a_band_order, clk, rst, m_tvalid && !cal_bad,
    high_lvl >= low_lvl, "high threshold below low threshold")

endmodule

bind light_start_detector lsd_checker u_lsd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
